[hdl/mcsc_pkg.sv]
package mcsc_pkg;

   // Patch size limits
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 32;

   // Field and register widths
   localparam int ROWCNT_W   = 7;
   localparam int COLCNT_W   = 6;
   localparam int START_W    = 5;
   localparam int ERR_W      = 16;
   localparam int PAIR_W     = ERR_W + 1;
   localparam int COST_W     = 23;
   localparam int MOVE_W     = 2;
   localparam int ROW_IDX_W  = 6;
   localparam int ONES_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - ROW_IDX_W - ONES_W;

   // Derived index widths
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CIDX_W     = $clog2(MAX_COLS);
   localparam int KCNT_W     = $clog2(MAX_COLS + 1);
   localparam int ERR_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ERR_AW     = $clog2(ERR_DEPTH);
   localparam int TOTAL_W    = ERR_AW + 1;
   localparam int COST_DEPTH = 2 * MAX_COLS;
   localparam int COST_AW    = CIDX_W + 1;
   localparam int MOVE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MOVE_AW    = ROW_W + CIDX_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLUMN = 2'd2;

   // Register reset values
   localparam logic [ROWCNT_W-1:0] RST_ROW_COUNT    = 7'd64;
   localparam logic [COLCNT_W-1:0] RST_COL_COUNT    = 6'd32;
   localparam logic [START_W-1:0]  RST_START_COLUMN = 5'd2;

   // Move codes
   localparam logic [MOVE_W-1:0] MOVE_CENTRE = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_LEFT   = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_RIGHT  = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROW,
      ST_TRACE,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic [COST_W-1:0] left;
      logic [COST_W-1:0] centre;
      logic [COST_W-1:0] right;
      logic              left_ok;
      logic              right_ok;
      logic              bottom;
      logic [PAIR_W-1:0] pair;
   } cell_in_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [MOVE_W-1:0] move;
   } cell_out_type;

endpackage

[hdl/mcsc_ram.sv]
module mcsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mcsc_cell.sv]
module mcsc_cell (
   input  mcsc_pkg::cell_in_type  cell_in,
   output mcsc_pkg::cell_out_type cell_out
);
   import mcsc_pkg::*;

   logic [COST_W-1:0] best;
   logic [MOVE_W-1:0] move;

   // Centre wins ties; left only when strictly lower; right only when strictly
   // below the better of the two.
   always_comb begin
      best = cell_in.centre;
      move = MOVE_CENTRE;
      if (cell_in.left_ok && (cell_in.left < best)) begin
         best = cell_in.left;
         move = MOVE_LEFT;
      end
      if (cell_in.right_ok && (cell_in.right < best)) begin
         best = cell_in.right;
         move = MOVE_RIGHT;
      end
   end

   always_comb begin
      if (cell_in.bottom) begin
         cell_out.cost = COST_W'(cell_in.pair);
      end else begin
         cell_out.cost = COST_W'(cell_in.pair) + best;
      end
      cell_out.move = move;
   end

endmodule

[hdl/min_cost_seam_cut.sv]
// Minimum-error seam cut over an overlap error patch. Load row_count x col_count
// squared-error samples in row-major order, one word per cycle on req_. Once
// the last sample of a patch is in, the block sums adjacent column pairs into
// cost cells, accumulates costs from the bottom row upward (each cell adds the
// least of its three lower neighbours, centre winning ties, then left) and
// stores a move per cell; it then traces the seam down from start_column and
// sends one rsp_ word per patch row giving the number of leading ones in that
// row's mask, with rsp_tlast on the final row. The cost pass streams one sample
// and one cost cell per cycle out of the sample and cost memories. Up to the
// start row the trace sends each row directly; after it, each row first reads
// the move memory for the row above (ST_TRACE, then ST_STEP), and the trace
// waits while rsp_tready is low. req_tready is low from the last sample of a
// patch until its final result sits in the output register; the next patch
// may load while that result waits. Configuration is taken only while the
// block is idle, and a write to row_count or col_count drops a partly loaded
// patch.
module min_cost_seam_cut (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mcsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcsc_pkg::CSR_DATA_W-1:0]    csr_data,
   // sample stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mcsc_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] err_value
   // mask row stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mcsc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [5:0] row_index,
                                                            // [11:6] ones_count,
                                                            // [15:12] zero
   output logic                               rsp_tlast    // last_row
);
   import mcsc_pkg::*;

   // control state
   state_type           state_ff,        state_in;
   logic [ROWCNT_W-1:0] row_count_ff,    row_count_in;
   logic [COLCNT_W-1:0] col_count_ff,    col_count_in;
   logic [START_W-1:0]  start_column_ff, start_column_in;
   logic [TOTAL_W-1:0]  load_count_ff,   load_count_in;
   logic [ROW_W-1:0]    row_ff,          row_in;
   logic [KCNT_W-1:0]   k_ff,            k_in;
   logic [ERR_AW-1:0]   base_ff,         base_in;
   logic                bottom_ff,       bottom_in;
   logic [ROW_W-1:0]    trace_row_ff,    trace_row_in;
   logic [CIDX_W-1:0]   start_ff,        start_in;
   logic [CIDX_W-1:0]   col_ff,          col_in;
   logic                rsp_valid_ff,    rsp_valid_in;

   // payload
   logic [ROW_IDX_W-1:0] rsp_row_ff,  rsp_row_in;
   logic [ONES_W-1:0]    rsp_ones_ff, rsp_ones_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [ERR_W-1:0]     e_prev_ff,   e_prev_in;
   logic [COST_W-1:0]    c_m1_ff,     c_m1_in;
   logic [COST_W-1:0]    c_m2_ff,     c_m2_in;

   // effective sizes
   logic [ROWCNT_W-1:0] eff_rows;
   logic [COLCNT_W-1:0] eff_cols;
   logic [TOTAL_W-1:0]  total;
   logic [COLCNT_W-1:0] start_clamp;
   logic [ROW_W-1:0]    last_row_idx;

   // memory ports
   logic                err_we,  err_re;
   logic [ERR_AW-1:0]   err_wa,  err_ra;
   logic [ERR_W-1:0]    err_rd;
   logic                cost_we, cost_re;
   logic [COST_AW-1:0]  cost_wa, cost_ra;
   logic [COST_W-1:0]   cost_rd;
   logic                move_we, move_re;
   logic [MOVE_AW-1:0]  move_wa, move_ra;
   logic [MOVE_W-1:0]   move_rd;

   cell_in_type         cell_in;
   cell_out_type        cell_out;
   logic [KCNT_W-1:0]   cell_j;
   logic                cell_fire;
   logic                rsp_free;
   logic                rsp_load;
   logic [CIDX_W-1:0]   col_next;

   // Clamp the size registers into their legal ranges.
   always_comb begin
      if (row_count_ff < ROWCNT_W'(2)) begin
         eff_rows = ROWCNT_W'(2);
      end else if (row_count_ff > ROWCNT_W'(MAX_ROWS)) begin
         eff_rows = ROWCNT_W'(MAX_ROWS);
      end else begin
         eff_rows = row_count_ff;
      end
      if (col_count_ff < COLCNT_W'(3)) begin
         eff_cols = COLCNT_W'(3);
      end else if (col_count_ff > COLCNT_W'(MAX_COLS)) begin
         eff_cols = COLCNT_W'(MAX_COLS);
      end else begin
         eff_cols = col_count_ff;
      end
      // start column: raise to 1, then lower to the last cost cell
      start_clamp = COLCNT_W'(start_column_ff);
      if (start_clamp < COLCNT_W'(1)) begin
         start_clamp = COLCNT_W'(1);
      end
      if (start_clamp > eff_cols - COLCNT_W'(2)) begin
         start_clamp = eff_cols - COLCNT_W'(2);
      end
   end

   assign total        = TOTAL_W'(eff_rows) * TOTAL_W'(eff_cols);
   assign last_row_idx = ROW_W'(eff_rows - ROWCNT_W'(1));

   // Cost cell window: in the cost pass, the memories return sample k-1 and
   // the below-row cost k-1 in the cycle the column counter shows k, so the
   // cell being finished is j = k-2.
   assign cell_j    = k_ff - KCNT_W'(2);
   assign cell_fire = (state_ff == ST_ROW) && (k_ff >= KCNT_W'(2));

   always_comb begin
      cell_in.pair     = PAIR_W'(e_prev_ff) + PAIR_W'(err_rd);
      cell_in.left     = c_m2_ff;
      cell_in.centre   = c_m1_ff;
      cell_in.right    = cost_rd;
      cell_in.left_ok  = k_ff > KCNT_W'(2);
      cell_in.right_ok = k_ff != KCNT_W'(eff_cols);
      cell_in.bottom   = bottom_ff;
   end

   mcsc_cell u_cell (
      .cell_in  (cell_in),
      .cell_out (cell_out)
   );

   // Step the seam by the move read from the row above, kept inside the row.
   always_comb begin
      col_next = col_ff;
      if ((move_rd == MOVE_LEFT) && (col_ff != '0)) begin
         col_next = col_ff - CIDX_W'(1);
      end else if ((move_rd == MOVE_RIGHT) &&
                   (COLCNT_W'(col_ff) + COLCNT_W'(2) < eff_cols)) begin
         col_next = col_ff + CIDX_W'(1);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next state and datapath control.
   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      col_count_in    = col_count_ff;
      start_column_in = start_column_ff;
      load_count_in   = load_count_ff;
      row_in          = row_ff;
      k_in            = k_ff;
      base_in         = base_ff;
      bottom_in       = bottom_ff;
      trace_row_in    = trace_row_ff;
      start_in        = start_ff;
      col_in          = col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_ones_in     = rsp_ones_ff;
      rsp_last_in     = rsp_last_ff;
      e_prev_in       = e_prev_ff;
      c_m1_in         = c_m1_ff;
      c_m2_in         = c_m2_ff;
      rsp_load        = 1'b0;

      req_tready = (state_ff == ST_LOAD);
      err_we     = 1'b0;
      err_wa     = load_count_ff[ERR_AW-1:0];
      err_re     = 1'b0;
      err_ra     = base_ff + ERR_AW'(k_ff);
      cost_re    = 1'b0;
      cost_ra    = {~row_ff[0], k_ff[CIDX_W-1:0]};
      cost_we    = cell_fire;
      cost_wa    = {row_ff[0], cell_j[CIDX_W-1:0]};
      move_we    = cell_fire && !bottom_ff;
      move_wa    = {row_ff, cell_j[CIDX_W-1:0]};
      move_re    = 1'b0;
      move_ra    = {trace_row_ff - ROW_W'(1), col_ff};

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               err_we = 1'b1;
               if (load_count_ff + TOTAL_W'(1) == total) begin
                  // patch complete: start the cost pass on the bottom row
                  load_count_in = '0;
                  row_in        = last_row_idx;
                  base_in       = ERR_AW'(total - TOTAL_W'(eff_cols));
                  k_in          = '0;
                  bottom_in     = 1'b1;
                  state_in      = ST_ROW;
               end else begin
                  load_count_in = load_count_ff + TOTAL_W'(1);
               end
            end
         end
         ST_ROW: begin
            // the row below sits in the other cost bank, so reads and writes
            // never meet on one entry
            if (k_ff < KCNT_W'(eff_cols)) begin
               err_re  = 1'b1;
               cost_re = 1'b1;
            end
            if (k_ff != '0) begin
               e_prev_in = err_rd;
               c_m2_in   = c_m1_ff;
               c_m1_in   = cost_rd;
            end
            if (k_ff == KCNT_W'(eff_cols)) begin
               if (row_ff == '0) begin
                  trace_row_in = '0;
                  start_in     = CIDX_W'(start_clamp);
                  state_in     = ST_TRACE;
               end else begin
                  row_in    = row_ff - ROW_W'(1);
                  base_in   = base_ff - ERR_AW'(eff_cols);
                  k_in      = '0;
                  bottom_in = 1'b0;
               end
            end else begin
               k_in = k_ff + KCNT_W'(1);
            end
         end
         ST_TRACE: begin
            if (trace_row_ff > ROW_W'(start_ff)) begin
               // fetch the move of the row above at the current column
               move_re  = 1'b1;
               state_in = ST_STEP;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               if (trace_row_ff == ROW_W'(start_ff)) begin
                  rsp_ones_in = ONES_W'(start_ff);
                  col_in      = start_ff;
               end else begin
                  rsp_ones_in = '0;
               end
            end
         end
         ST_STEP: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_ones_in = ONES_W'(col_next) + ONES_W'(1);
               col_in      = col_next;
            end
         end
      endcase

      if (rsp_load) begin
         rsp_row_in  = ROW_IDX_W'(trace_row_ff);
         rsp_last_in = (trace_row_ff == last_row_idx);
         if (trace_row_ff == last_row_idx) begin
            state_in = ST_LOAD;
         end else begin
            trace_row_in = trace_row_ff + ROW_W'(1);
            state_in     = ST_TRACE;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // configuration writes; a size change drops a partial patch
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_in  = csr_data[ROWCNT_W-1:0];
               load_count_in = '0;
            end
            CSR_COL_COUNT: begin
               col_count_in  = csr_data[COLCNT_W-1:0];
               load_count_in = '0;
            end
            CSR_START_COLUMN: begin
               start_column_in = csr_data[START_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // take configuration only in the load state, never during the cost pass or trace
   assign csr_ready = (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_count_ff    <= RST_ROW_COUNT;
         col_count_ff    <= RST_COL_COUNT;
         start_column_ff <= RST_START_COLUMN;
         load_count_ff   <= '0;
         row_ff          <= '0;
         k_ff            <= '0;
         base_ff         <= '0;
         bottom_ff       <= 1'b0;
         trace_row_ff    <= '0;
         start_ff        <= '0;
         col_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         col_count_ff    <= col_count_in;
         start_column_ff <= start_column_in;
         load_count_ff   <= load_count_in;
         row_ff          <= row_in;
         k_ff            <= k_in;
         base_ff         <= base_in;
         bottom_ff       <= bottom_in;
         trace_row_ff    <= trace_row_in;
         start_ff        <= start_in;
         col_ff          <= col_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_ones_ff <= rsp_ones_in;
      rsp_last_ff <= rsp_last_in;
      e_prev_ff   <= e_prev_in;
      c_m1_ff     <= c_m1_in;
      c_m2_ff     <= c_m2_in;
   end

   // loaded samples
   mcsc_ram #(.WIDTH(ERR_W), .DEPTH(ERR_DEPTH)) u_err_ram (
      .clock   (clock),
      .wr_en   (err_we),
      .wr_addr (err_wa),
      .wr_data (req_tdata[ERR_W-1:0]),
      .rd_en   (err_re),
      .rd_addr (err_ra),
      .rd_data (err_rd)
   );

   // two banks of cost cells, alternating by row parity
   mcsc_ram #(.WIDTH(COST_W), .DEPTH(COST_DEPTH)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (cost_wa),
      .wr_data (cell_out.cost),
      .rd_en   (cost_re),
      .rd_addr (cost_ra),
      .rd_data (cost_rd)
   );

   // one move per cell, addressed by row and column
   mcsc_ram #(.WIDTH(MOVE_W), .DEPTH(MOVE_DEPTH)) u_move_ram (
      .clock   (clock),
      .wr_en   (move_we),
      .wr_addr (move_wa),
      .wr_data (cell_out.move),
      .rd_en   (move_re),
      .rd_addr (move_ra),
      .rd_data (move_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ones_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the load count never runs past the patch size
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (load_count_ff < total))
      else $error("load count beyond patch size");

   // cost pass reads stay inside the loaded patch
   a_err_read_bound: assert property (@(posedge clock) disable iff (reset)
      err_re |-> (TOTAL_W'(err_ra) < total))
      else $error("sample read outside patch");

   // the traced seam stays on a cell that has a right neighbour's pair
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (COLCNT_W'(col_ff) + COLCNT_W'(2) <= eff_cols))
      else $error("seam column outside row");

   // results within a run come out in row order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (trace_row_ff != '0)) |->
         (ROW_IDX_W'(trace_row_ff) == rsp_row_ff + ROW_IDX_W'(1)))
      else $error("result row out of order");
`endif

endmodule
